FILE: hw/rtl/motivational_task_selector_assert.svh
// Assertion macros shared by the selector RTL.
`ifndef MOTIVATIONAL_TASK_SELECTOR_ASSERT_SVH
`define MOTIVATIONAL_TASK_SELECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("motivational_task_selector: check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("motivational_task_selector: check failed");

`endif

FILE: hw/rtl/mts_pkg.sv
package mts_pkg;

  localparam int TIME_W = 32;
  localparam int MOT_W  = 13;
  localparam int RATE_W = 5;
  localparam int GIVE_W = 10;

  localparam logic [MOT_W-1:0] MOT_MAX = '1;

  // Configuration register map.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ROBOT     = 3'd0,
    CFG_THRESHOLD     = 3'd1,
    CFG_HEARD_TIMEOUT = 3'd2,
    CFG_STALE_TIMEOUT = 3'd3,
    CFG_HANDOVER_TIME = 3'd4,
    CFG_TASK_ENABLE   = 3'd5
  } cfg_reg_t;

  localparam logic [1:0]  RST_OWN_ROBOT     = 2'd0;
  localparam logic [11:0] RST_THRESHOLD     = 12'd2000;
  localparam logic [15:0] RST_HEARD_TIMEOUT = 16'd5;
  localparam logic [15:0] RST_STALE_TIMEOUT = 16'd360;
  localparam logic [15:0] RST_HANDOVER_TIME = 16'd120;
  localparam logic [3:0]  RST_TASK_ENABLE   = 4'hF;

  // One task-activity message.
  typedef struct packed {
    logic [1:0]        task_id;
    logic [1:0]        sender_id;
    logic [TIME_W-1:0] time_now;
  } msg_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]       selected_task;
    logic [MOT_W-1:0] motivation_idle;
    logic [MOT_W-1:0] motivation_wander;
    logic [MOT_W-1:0] motivation_overwatch;
    logic [MOT_W-1:0] motivation_report;
    logic [3:0]       acquiescence_bits;
    logic [3:0]       suppression_bits;
    logic [3:0]       reset_bits;
  } res_t;

  // Impatience rates in half units while another robot holds the task.
  // Tasks beyond the report task reuse its values.
  function automatic logic [RATE_W-1:0] rate_slow(input logic [3:0] task_idx);
    logic [RATE_W-1:0] rate;
    case (task_idx)
      4'd0:    rate = 5'd2;
      4'd1:    rate = 5'd5;
      4'd2:    rate = 5'd10;
      default: rate = 5'd4;
    endcase
    return rate;
  endfunction

  // Impatience rates in half units while the task is free.
  function automatic logic [RATE_W-1:0] rate_fast(input logic [3:0] task_idx);
    logic [RATE_W-1:0] rate;
    case (task_idx)
      4'd0:    rate = 5'd2;
      4'd1:    rate = 5'd10;
      4'd2:    rate = 5'd20;
      default: rate = 5'd6;
    endcase
    return rate;
  endfunction

  // Active seconds after which a task is given up unconditionally.
  function automatic logic [GIVE_W-1:0] give_up(input logic [3:0] task_idx);
    logic [GIVE_W-1:0] secs;
    if (task_idx == 4'd0) begin
      secs = 10'd720;
    end else begin
      secs = 10'd420;
    end
    return secs;
  endfunction

endpackage

FILE: hw/rtl/mts_stream_if.sv
// Valid/ready channel carrying one payload per beat.
interface mts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/motivational_task_selector.sv
// Channel   Dir  Payload            Beat meaning
// msg       in   mts_pkg::msg_t     one task-activity message (task, robot, time)
// res       out  mts_pkg::res_t     selected task, motivations and gate flags
// cfg_*     in   index + 16b data   single-cycle register write, no read-back
//
// Throughput is one message per cycle while the result is not stalled; the
// result beat of a message passes the message register, then the result register.
// The whole per-message update of the task table is done in the cycle a
// message leaves the message register, so back-to-back messages see each
// other's state. A stalled result holds the result register, and the message
// register takes a beat while it is empty or the result register can advance.
// Reset is synchronous: it restores all configuration registers and the
// task table; message and result payloads are not reset.
`include "motivational_task_selector_assert.svh"

module motivational_task_selector #(
  parameter int NUM_TASKS  = 4,
  parameter int NUM_ROBOTS = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  mts_stream_if.sink                         msg,
  mts_stream_if.source                       res,
  input  logic                               cfg_wen,
  input  logic [mts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Messages carry 2-bit task and robot ids, so only the first four tasks
  // and robots can ever be addressed by a message.
  localparam int MSG_TASKS  = (NUM_TASKS  < 4) ? NUM_TASKS  : 4;
  localparam int MSG_ROBOTS = (NUM_ROBOTS < 4) ? NUM_ROBOTS : 4;
  localparam int TI_W = $clog2(MSG_TASKS);
  localparam int RI_W = $clog2(MSG_ROBOTS);
  localparam int TK_W = $clog2(NUM_TASKS);
  localparam int OUT_TASKS = MSG_TASKS;

  localparam int TIME_W = mts_pkg::TIME_W;
  localparam int MOT_W  = mts_pkg::MOT_W;
  localparam int RATE_W = mts_pkg::RATE_W;

  // Configuration registers.
  logic [1:0]  own_robot;
  logic [11:0] threshold;
  logic [15:0] heard_timeout;
  logic [15:0] stale_timeout;
  logic [15:0] handover_time;
  logic [3:0]  task_enable;

  // Per task and robot bookkeeping.
  logic [TIME_W-1:0] last_seen  [MSG_TASKS][MSG_ROBOTS];
  logic              heard_flag [MSG_TASKS][MSG_ROBOTS];
  logic              stale_flag [MSG_TASKS][MSG_ROBOTS];

  // Per task state.
  logic [TIME_W-1:0]    active_secs [NUM_TASKS];
  logic [RATE_W-1:0]    imp_rate    [NUM_TASKS];
  logic [NUM_TASKS-1:0] reset_gate;
  logic [NUM_TASKS-1:0] acq_gate;
  logic [NUM_TASKS-1:0] act_gate;
  logic [MOT_W-1:0]     prev_mot    [NUM_TASKS];
  logic [1:0]           chosen_task;
  logic [TK_W-1:0]      own_task;

  // Pipeline registers.
  logic          stg_valid;
  mts_pkg::msg_t stg;
  logic          res_valid;
  mts_pkg::res_t res_q;

  // Next-state values of the update.
  logic [TIME_W-1:0]    active_secs_next [NUM_TASKS];
  logic [RATE_W-1:0]    imp_rate_next    [NUM_TASKS];
  logic [NUM_TASKS-1:0] reset_gate_next;
  logic [NUM_TASKS-1:0] acq_gate_next;
  logic [NUM_TASKS-1:0] act_gate_next;
  logic [MOT_W-1:0]     prev_mot_next    [NUM_TASKS];
  logic [1:0]           chosen_task_next;
  logic [TK_W-1:0]      own_task_next;
  logic                 heard_next;
  logic                 stale_next;
  mts_pkg::res_t        res_next;

  // Update datapath signals.
  logic              advance;
  logic              fire;
  logic              in_range;
  logic              is_own;
  logic [TI_W-1:0]   t_idx;
  logic [RI_W-1:0]   r_idx;
  logic [TK_W-1:0]   t_big;
  logic [3:0]        t_tab;
  logic [TIME_W-1:0] seen_old;
  logic [TIME_W-1:0] diff;
  logic [TIME_W:0]   act_sum;
  logic [TIME_W-1:0] act_new;
  logic              acq_hit;
  logic [MOT_W-1:0]  level;
  logic [MOT_W:0]    mot_sum;
  logic [MOT_W-1:0]  mot      [NUM_TASKS];
  logic [MOT_W-1:0]  mot_out  [4];
  logic [3:0]        acq_bits;
  logic [3:0]        sup_bits;
  logic [3:0]        rst_bits;

  // Handshake: the message register moves whenever the result register can.
  assign advance   = !res_valid || res.ready;
  assign fire      = stg_valid && advance;
  assign msg.ready = !stg_valid || advance;
  assign res.valid = res_valid;
  assign res.data  = res_q;

  assign in_range = ({1'b0, stg.task_id} < 3'(MSG_TASKS)) &&
                    ({1'b0, stg.sender_id} < 3'(MSG_ROBOTS));
  assign t_idx    = stg.task_id[TI_W-1:0];
  assign r_idx    = stg.sender_id[RI_W-1:0];
  assign t_big    = TK_W'(stg.task_id);
  assign t_tab    = {2'b00, stg.task_id};
  assign is_own   = (stg.sender_id == own_robot);
  assign level    = {threshold, 1'b0};

  // A zero time stamp means the pair was never heard from, which gives a
  // zero difference. Differences wrap modulo 2^32.
  assign seen_old = last_seen[t_idx][r_idx];
  assign diff     = (seen_old == '0) ? '0 : stg.time_now - seen_old;
  assign act_sum  = {1'b0, active_secs[t_big]} + {1'b0, diff};

  always_comb begin
    active_secs_next = active_secs;
    imp_rate_next    = imp_rate;
    reset_gate_next  = reset_gate;
    acq_gate_next    = acq_gate;
    act_gate_next    = act_gate;
    chosen_task_next = chosen_task;
    own_task_next    = own_task;
    heard_next       = heard_flag[t_idx][r_idx];
    stale_next       = stale_flag[t_idx][r_idx];
    act_new          = active_secs[t_big];
    acq_hit          = 1'b0;
    mot_sum          = '0;

    // Message bookkeeping. Our own report accumulates active time; a report
    // from another robot updates whether the task is heard and stale.
    if (is_own) begin
      own_task_next = t_big;
      heard_next    = 1'b1;
      act_new       = act_sum[TIME_W] ? '1 : act_sum[TIME_W-1:0];
      active_secs_next[t_big] = act_new;
    end else begin
      heard_next = (diff < {16'd0, heard_timeout});
      reset_gate_next[t_big] = !heard_next;
      if (diff < {16'd0, stale_timeout}) begin
        stale_next = 1'b0;
      end else if (diff > {16'd0, stale_timeout}) begin
        stale_next = 1'b1;
        reset_gate_next[t_big] = 1'b1;
      end
    end

    // Impatience slows down while someone else visibly holds the task.
    imp_rate_next[t_big] = (heard_next && !stale_next) ? mts_pkg::rate_slow(t_tab)
                                                       : mts_pkg::rate_fast(t_tab);

    // Acquiescence: yield after the handover time if others do the task,
    // or after the give-up time in any case; only idle stays active.
    acq_hit = ((act_new > {16'd0, handover_time}) && heard_next) ||
              (act_new > TIME_W'(mts_pkg::give_up(t_tab)));
    acq_gate_next[t_big] = !acq_hit;
    if (acq_hit) begin
      act_gate_next = '0;
      act_gate_next[0] = 1'b1;
      imp_rate_next[t_big] = mts_pkg::rate_slow(t_tab);
    end

    // Motivation: grows by the impatience rate while every gate is open,
    // otherwise drops to zero. Tasks with no enable bit are disabled.
    for (int i = 0; i < NUM_TASKS; i++) begin
      mot[i] = '0;
      if ((i < 4) && task_enable[i % 4] && act_gate_next[i] && reset_gate_next[i] &&
          acq_gate_next[i]) begin
        mot_sum = {1'b0, prev_mot[i]} + (MOT_W + 1)'(imp_rate_next[i]);
        mot[i]  = mot_sum[MOT_W] ? mts_pkg::MOT_MAX : mot_sum[MOT_W-1:0];
      end
    end

    // Selection: the highest-numbered task at or above the level wins. Winners are
    // clamped to the level, losers lose their accumulated active time.
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (mot[i] >= level) begin
        chosen_task_next = 2'(i);
        prev_mot_next[i] = level;
      end else begin
        prev_mot_next[i] = mot[i];
        active_secs_next[i] = '0;
      end
    end

    // Suppression: while idle or yielding, every task may run again;
    // otherwise only our own task (and idle, as it stands) stays active.
    if ((own_task_next == '0) || !acq_gate_next[own_task_next]) begin
      act_gate_next   = '1;
      reset_gate_next = '1;
    end else begin
      for (int i = 1; i < NUM_TASKS; i++) begin
        act_gate_next[i] = (TK_W'(i) == own_task_next);
      end
    end
  end

  // Result formatting. A message that addresses no known task or robot
  // reports the stored state unchanged.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mot_out[i] = '0;
    end
    acq_bits = '0;
    sup_bits = '0;
    rst_bits = '0;
    for (int i = 0; i < OUT_TASKS; i++) begin
      mot_out[i]  = in_range ? mot[i] : prev_mot[i];
      acq_bits[i] = in_range ? acq_gate_next[i]   : acq_gate[i];
      sup_bits[i] = in_range ? act_gate_next[i]   : act_gate[i];
      rst_bits[i] = in_range ? reset_gate_next[i] : reset_gate[i];
    end
    res_next.selected_task        = in_range ? chosen_task_next : chosen_task;
    res_next.motivation_idle      = mot_out[0];
    res_next.motivation_wander    = mot_out[1];
    res_next.motivation_overwatch = mot_out[2];
    res_next.motivation_report    = mot_out[3];
    res_next.acquiescence_bits    = acq_bits;
    res_next.suppression_bits     = sup_bits;
    res_next.reset_bits           = rst_bits;
  end

  // Message register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (msg.ready) begin
        stg_valid <= msg.valid;
      end
      if (advance) begin
        res_valid <= stg_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      stg <= msg.data;
    end
    if (fire) begin
      res_q <= res_next;
    end
  end

  // Configuration registers. User writes need no message in flight; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_robot     <= mts_pkg::RST_OWN_ROBOT;
      threshold     <= mts_pkg::RST_THRESHOLD;
      heard_timeout <= mts_pkg::RST_HEARD_TIMEOUT;
      stale_timeout <= mts_pkg::RST_STALE_TIMEOUT;
      handover_time <= mts_pkg::RST_HANDOVER_TIME;
      task_enable   <= mts_pkg::RST_TASK_ENABLE;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        mts_pkg::CFG_OWN_ROBOT:     own_robot     <= cfg_data[1:0];
        mts_pkg::CFG_THRESHOLD:     threshold     <= cfg_data[11:0];
        mts_pkg::CFG_HEARD_TIMEOUT: heard_timeout <= cfg_data;
        mts_pkg::CFG_STALE_TIMEOUT: stale_timeout <= cfg_data;
        mts_pkg::CFG_HANDOVER_TIME: handover_time <= cfg_data;
        mts_pkg::CFG_TASK_ENABLE:   task_enable   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Task table. Only a message that addresses a known task and robot
  // changes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MSG_TASKS; t++) begin
        for (int r = 0; r < MSG_ROBOTS; r++) begin
          last_seen[t][r]  <= '0;
          heard_flag[t][r] <= 1'b0;
          stale_flag[t][r] <= 1'b0;
        end
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
        active_secs[i] <= '0;
        imp_rate[i]    <= mts_pkg::rate_fast(4'(i));
        prev_mot[i]    <= '0;
      end
      reset_gate  <= '1;
      acq_gate    <= '1;
      act_gate    <= '0;
      chosen_task <= '0;
      own_task    <= '0;
    end else if (fire && in_range) begin
      last_seen[t_idx][r_idx]  <= stg.time_now;
      heard_flag[t_idx][r_idx] <= heard_next;
      stale_flag[t_idx][r_idx] <= stale_next;
      active_secs <= active_secs_next;
      imp_rate    <= imp_rate_next;
      prev_mot    <= prev_mot_next;
      reset_gate  <= reset_gate_next;
      acq_gate    <= acq_gate_next;
      act_gate    <= act_gate_next;
      chosen_task <= chosen_task_next;
      own_task    <= own_task_next;
    end
  end

  // A message leaving the message register always produces a result beat.
  `MTS_ASSERT_NEXT(a_fire_gives_result, clk, rst, fire, res.valid)
  // Messages outside the task or robot range leave the selection alone.
  `MTS_ASSERT_NEXT(a_bad_msg_keeps_choice, clk, rst, fire && !in_range,
                   chosen_task == $past(chosen_task))
  // After suppression our own task is always allowed to run.
  `MTS_ASSERT_NEXT(a_own_task_active, clk, rst, fire && in_range, act_gate[own_task])
  // A full message register behind a stalled result blocks new messages.
  `MTS_ASSERT_SAME(a_stall_blocks_input, clk, rst, stg_valid && res_valid && !res.ready,
                   !msg.ready)

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TASKS  = 4;
  localparam int NUM_ROBOTS = 3;

  // The selector keeps a small model of the robot team. This class mirrors
  // that state. Every accepted message beat advances the mirror and queues
  // the result beat the block must produce for it. Result beats are checked
  // against that queue in order.
  class selector_scoreboard;
    bit [1:0]  own_robot = mts_pkg::RST_OWN_ROBOT;
    bit [11:0] threshold = mts_pkg::RST_THRESHOLD;
    bit [15:0] heard_timeout = mts_pkg::RST_HEARD_TIMEOUT;
    bit [15:0] stale_timeout = mts_pkg::RST_STALE_TIMEOUT;
    bit [15:0] handover_time = mts_pkg::RST_HANDOVER_TIME;
    bit [3:0]  task_enable = mts_pkg::RST_TASK_ENABLE;

    bit [4:0]  slow_rate[NUM_TASKS] = '{5'd2, 5'd5, 5'd10, 5'd4};
    bit [4:0]  fast_rate[NUM_TASKS] = '{5'd2, 5'd10, 5'd20, 5'd6};
    bit [9:0]  give_up_secs[NUM_TASKS] = '{10'd720, 10'd420, 10'd420, 10'd420};

    bit [31:0] last_seen[NUM_TASKS][NUM_ROBOTS];
    bit        heard[NUM_TASKS][NUM_ROBOTS];
    bit        stale[NUM_TASKS][NUM_ROBOTS];
    bit [31:0] active_secs[NUM_TASKS];
    bit [4:0]  impatience[NUM_TASKS];
    bit [NUM_TASKS-1:0] reset_gate = '1;
    bit [NUM_TASKS-1:0] acq_gate = '1;
    bit [NUM_TASKS-1:0] act_gate = '0;
    bit [mts_pkg::MOT_W-1:0] prev_mot[NUM_TASKS];
    bit [1:0]  chosen_task;
    bit [1:0]  own_task;

    mts_pkg::res_t pending_results[$];
    int        errors;
    int        messages;
    int        results;

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        impatience[i] = fast_rate[i];
        active_secs[i] = '0;
        prev_mot[i] = '0;
        for (int j = 0; j < NUM_ROBOTS; j++) begin
          last_seen[i][j] = '0;
          heard[i][j] = 1'b0;
          stale[i][j] = 1'b0;
        end
      end
    endfunction

    function void note_register(logic [mts_pkg::CFG_IDX_W-1:0] idx,
                                logic [mts_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        mts_pkg::CFG_OWN_ROBOT:     own_robot = value[1:0];
        mts_pkg::CFG_THRESHOLD:     threshold = value[11:0];
        mts_pkg::CFG_HEARD_TIMEOUT: heard_timeout = value;
        mts_pkg::CFG_STALE_TIMEOUT: stale_timeout = value;
        mts_pkg::CFG_HANDOVER_TIME: handover_time = value;
        mts_pkg::CFG_TASK_ENABLE:   task_enable = value[3:0];
        default: ;
      endcase
    endfunction

    function void note_message(mts_pkg::msg_t m);
      bit [mts_pkg::MOT_W-1:0] mot[NUM_TASKS];
      bit [mts_pkg::MOT_W:0]   sum;
      bit [32:0]               acc;
      bit [31:0]               diff;
      bit [mts_pkg::MOT_W-1:0] level;
      int                      t;
      int                      r;
      mts_pkg::res_t           want;
      level = {threshold, 1'b0};
      t = m.task_id;
      r = m.sender_id;
      messages++;
      for (int i = 0; i < NUM_TASKS; i++) mot[i] = prev_mot[i];

      // A robot outside the team leaves every piece of state untouched.
      if (t < NUM_TASKS && r < NUM_ROBOTS) begin
        // A zero timestamp marks a pair never heard from.
        if (last_seen[t][r] == '0) last_seen[t][r] = m.time_now;
        diff = m.time_now - last_seen[t][r];
        if (r == own_robot) begin
          own_task = t[1:0];
          heard[t][r] = 1'b1;
          acc = {1'b0, active_secs[t]} + {1'b0, diff};
          active_secs[t] = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
        end else begin
          if (diff < heard_timeout) begin
            heard[t][r] = 1'b1;
            reset_gate[t] = 1'b0;
          end else begin
            heard[t][r] = 1'b0;
            reset_gate[t] = 1'b1;
          end
          // Exactly at the stale limit the flag holds its value.
          if (diff < stale_timeout) begin
            stale[t][r] = 1'b0;
          end else if (diff > stale_timeout) begin
            stale[t][r] = 1'b1;
            reset_gate[t] = 1'b1;
          end
        end
        last_seen[t][r] = m.time_now;

        impatience[t] = (heard[t][r] && !stale[t][r]) ? slow_rate[t] : fast_rate[t];

        if ((active_secs[t] > handover_time && heard[t][r]) ||
            active_secs[t] > give_up_secs[t]) begin
          acq_gate[t] = 1'b0;
          act_gate = 4'b0001;
          impatience[t] = slow_rate[t];
        end else begin
          acq_gate[t] = 1'b1;
        end

        for (int i = 0; i < NUM_TASKS; i++) begin
          if (task_enable[i] && act_gate[i] && reset_gate[i] && acq_gate[i]) begin
            sum = prev_mot[i] + impatience[i];
            mot[i] = (sum > mts_pkg::MOT_MAX) ? mts_pkg::MOT_MAX : sum[mts_pkg::MOT_W-1:0];
          end else begin
            mot[i] = '0;
          end
          prev_mot[i] = mot[i];
        end

        // The highest-numbered task at or above the level wins and is clamped to it.
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (mot[i] >= level) begin
            chosen_task = i[1:0];
            prev_mot[i] = level;
          end else begin
            active_secs[i] = '0;
          end
        end

        if (own_task == 2'd0 || !acq_gate[own_task]) begin
          act_gate = '1;
          reset_gate = '1;
        end else begin
          for (int i = 1; i < NUM_TASKS; i++) act_gate[i] = (i == own_task);
        end
      end

      want.selected_task = chosen_task;
      want.motivation_idle = mot[0];
      want.motivation_wander = mot[1];
      want.motivation_overwatch = mot[2];
      want.motivation_report = mot[3];
      want.acquiescence_bits = acq_gate;
      want.suppression_bits = act_gate;
      want.reset_bits = reset_gate;
      pending_results = {pending_results, want};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(mts_pkg::res_t got);
      mts_pkg::res_t want;
      results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat %h arrived with nothing expected", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("selected_task", want.selected_task, got.selected_task);
      compare_field("motivation_idle", want.motivation_idle, got.motivation_idle);
      compare_field("motivation_wander", want.motivation_wander, got.motivation_wander);
      compare_field("motivation_overwatch", want.motivation_overwatch,
                    got.motivation_overwatch);
      compare_field("motivation_report", want.motivation_report, got.motivation_report);
      compare_field("acquiescence_bits", want.acquiescence_bits, got.acquiescence_bits);
      compare_field("suppression_bits", want.suppression_bits, got.suppression_bits);
      compare_field("reset_bits", want.reset_bits, got.reset_bits);
    endfunction
  endclass

  // Clock, reset and the register write port. Every input starts at a known
  // value; reset is held at first and then released for good.
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wen = 1'b0;
  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Idle rates in percent for both sides of the block, changed per phase.
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  logic                  recv_ready = 1'b0;

  // Running clock of the robot team. Most messages move it forward by a few
  // seconds so that heard, stale, handover and give-up windows all get hit.
  logic [31:0]           team_clock = '0;
  int                    settings_used = 0;

  selector_scoreboard    sb = new();

  always #6 clk = ~clk;

  mts_stream_if #(.payload_t(mts_pkg::msg_t)) msg_ch ();
  mts_stream_if #(.payload_t(mts_pkg::res_t)) res_ch ();

  assign res_ch.ready = recv_ready;

  motivational_task_selector dut (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg_ch),
    .res       (res_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The receiver drops ready at random, so stalls land on every phase of a
  // result beat. With a zero rate ready stays high throughout.
  always @(posedge clk) begin
    recv_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Everything is sampled at the rising edge, where inputs and outputs both
  // still show the values they had before the edge. Register writes, message
  // beats and result beats are handed to the scoreboard in that order.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wen) begin
        sb.note_register(cfg_index, cfg_data);
      end
      if (msg_ch.valid && msg_ch.ready) begin
        sb.note_message(msg_ch.data);
      end
      if (res_ch.valid && res_ch.ready) begin
        sb.check_result(res_ch.data);
      end
    end
  end

  // Presents one message beat and returns at the edge that takes it. The
  // sender may first idle at random. Valid stays high on
  // return, so back-to-back beats never drop it in between.
  task automatic send_message(input logic [1:0] task_id, input logic [1:0] sender_id,
                              input logic [31:0] time_now);
    mts_pkg::msg_t m;
    m.task_id = task_id;
    m.sender_id = sender_id;
    m.time_now = time_now;
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.data <= m;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
  endtask

  // Holds the sender off until every expected result beat has come back,
  // then lets the two-stage pipeline settle. The first edge makes sure the
  // last accepted beat is already on the scoreboard.
  task automatic drain_results();
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all six registers on consecutive edges. The block must be idle.
  task automatic apply_setting(input logic [1:0] own, input logic [11:0] thr,
                               input logic [15:0] heard_to, input logic [15:0] stale_to,
                               input logic [15:0] handover, input logic [3:0] enables);
    logic [mts_pkg::CFG_DATA_W-1:0] values[6];
    mts_pkg::cfg_reg_t              regs[6];
    regs = '{mts_pkg::CFG_OWN_ROBOT, mts_pkg::CFG_THRESHOLD, mts_pkg::CFG_HEARD_TIMEOUT,
             mts_pkg::CFG_STALE_TIMEOUT, mts_pkg::CFG_HANDOVER_TIME,
             mts_pkg::CFG_TASK_ENABLE};
    values = '{{14'd0, own}, {4'd0, thr}, heard_to, stale_to, handover, {12'd0, enables}};
    for (int i = 0; i < 6; i++) begin
      cfg_wen <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= values[i];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    settings_used++;
  endtask

  // One random message. About half come from this robot so that its own
  // task, active time and acquiescence move; a few name a robot outside the
  // team. Time mostly creeps forward, with rarer long jumps, arbitrary
  // timestamps, values right below the wrap point and zero.
  task automatic send_random_message();
    int          pick;
    logic [1:0]  robot;
    pick = $urandom_range(99);
    if (pick < 4) begin
      robot = 2'd3;
    end else if (pick < 50) begin
      robot = sb.own_robot;
    end else begin
      robot = 2'($urandom_range(NUM_ROBOTS - 1));
    end
    pick = $urandom_range(99);
    if (pick < 78) begin
      team_clock = team_clock + $urandom_range(8);
    end else if (pick < 91) begin
      team_clock = team_clock + $urandom_range(800);
    end else if (pick < 95) begin
      team_clock = team_clock + $urandom_range(65535);
    end else if (pick < 97) begin
      team_clock = $urandom;
    end else if (pick < 99) begin
      team_clock = 32'hFFFF_FFFF - $urandom_range(3);
    end else begin
      team_clock = '0;
    end
    send_message(2'($urandom_range(NUM_TASKS - 1)), robot, team_clock);
  endtask

  initial begin
    // Per phase: own robot, threshold, heard and stale timeouts, handover
    // time, task enables, message count. The last phase draws its setting
    // at random.
    int          phase_items[6];
    logic [1:0]  p_own[6];
    logic [11:0] p_thr[6];
    logic [15:0] p_heard[6];
    logic [15:0] p_stale[6];
    logic [15:0] p_hand[6];
    logic [3:0]  p_en[6];

    phase_items = '{220, 190, 220, 190, 30, 300};
    p_own   = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
    p_thr   = '{12'd10, 12'd4000, 12'd1, 12'd40, 12'd5, 12'd0};
    p_heard = '{16'd5, 16'd65535, 16'd0, 16'd30, 16'd1000, 16'd0};
    p_stale = '{16'd360, 16'd65535, 16'd0, 16'd100, 16'd2000, 16'd0};
    p_hand  = '{16'd120, 16'd65535, 16'd0, 16'd50, 16'd300, 16'd0};
    p_en    = '{4'b1111, 4'b1010, 4'b1111, 4'b0101, 4'b0000, 4'b0000};

    msg_ch.valid = 1'b0;
    msg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset register values: a first message at
    // time zero, a robot outside the team, the heard window edge, a gap of
    // exactly the stale timeout and one second beyond, time running
    // backwards into a huge active time, and a timestamp of zero that turns
    // a known pair back into a never-seen one.
    send_message(2'd0, 2'd0, 32'd0);
    send_message(2'd3, 2'd3, 32'hFFFF_FFFF);
    send_message(2'd1, 2'd1, 32'd100);
    send_message(2'd1, 2'd1, 32'd102);
    send_message(2'd1, 2'd1, 32'd107);
    send_message(2'd2, 2'd2, 32'd1000);
    send_message(2'd2, 2'd2, 32'd1360);
    send_message(2'd2, 2'd2, 32'd1721);
    send_message(2'd2, 2'd2, 32'd1722);
    send_message(2'd3, 2'd0, 32'd50);
    send_message(2'd3, 2'd0, 32'd40);
    send_message(2'd0, 2'd1, 32'hFFFF_FFFF);
    send_message(2'd0, 2'd1, 32'd0);
    send_message(2'd0, 2'd1, 32'd3);
    send_message(2'd2, 2'd3, 32'h1234_5678);
    drain_results();

    // A threshold of one and no handover delay: tasks get selected at once and
    // our own robot yields whenever another robot is heard on its task.
    apply_setting(2'd0, 12'd1, 16'd5, 16'd360, 16'd0, 4'b1111);
    send_message(2'd2, 2'd0, 32'd10);
    send_message(2'd2, 2'd0, 32'd20);
    send_message(2'd2, 2'd0, 32'd25);
    send_message(2'd1, 2'd2, 32'd26);
    send_message(2'd1, 2'd2, 32'd27);
    send_message(2'd3, 2'd1, 32'd1000);
    send_message(2'd3, 2'd1, 32'hFFFF_FFFE);
    drain_results();

    // Random phases. The sender idles little and the receiver a lot first,
    // then the other way round, then neither side idles. Halfway through
    // each phase the sender waits until the block has answered everything.
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 68;
      end else if (p < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 5) begin
        apply_setting(2'($urandom_range(NUM_ROBOTS - 1)), 12'($urandom_range(1, 60)),
                      16'($urandom_range(500)), 16'($urandom_range(800)),
                      16'($urandom_range(500)), 4'($urandom_range(15)));
      end else begin
        apply_setting(p_own[p], p_thr[p], p_heard[p], p_stale[p], p_hand[p], p_en[p]);
      end
      team_clock = $urandom_range(1, 1000);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (i == phase_items[p] / 2) begin
          drain_results();
        end
        send_random_message();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d message beats and %0d result beats under %0d register settings,",
             sb.messages, sb.results, settings_used);
    $display("with sender and receiver stalls in both mixes and a stall-free stretch.");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this time.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected", sb.pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
